// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files; spw_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock while out of reset.
`define SPW_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define SPW_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

// ----- rtl/spw_pkg.sv -----
// Types, codes and permutation helpers of the sponge hash and wrap block.
`timescale 1ns / 1ps
`default_nettype none
package spw_pkg;

  localparam int POS_W = 6;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  typedef logic [511:0] state_t;

  localparam logic [1:0] FUNC_KEY  = 2'd0;
  localparam logic [1:0] FUNC_HDR  = 2'd1;
  localparam logic [1:0] FUNC_BODY = 2'd2;
  localparam logic [1:0] FUNC_TAG  = 2'd3;

  localparam logic [1:0] MODE_HASH   = 2'd0;
  localparam logic [1:0] MODE_WRAP   = 2'd1;
  localparam logic [1:0] MODE_UNWRAP = 2'd2;

  localparam logic [1:0] KIND_TEXT    = 2'd0;
  localparam logic [1:0] KIND_DIGEST  = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [1:0] CFG_MODE    = 2'd0;
  localparam logic [1:0] CFG_PAD_MSG = 2'd1;
  localparam logic [1:0] CFG_PAD_KS  = 2'd2;
  localparam logic [1:0] CFG_PAD_TAG = 2'd3;

  typedef enum logic [2:0] {
    OP_MSG,
    OP_KEY,
    OP_HDR,
    OP_BODY,
    OP_TAG
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       has;
    logic       ends;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] pad_msg;
    logic [7:0] pad_ks;
    logic [7:0] pad_tag;
    logic       clear;
  } cfg_t;

  localparam logic [31:0] RC [8] = '{
    32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
    32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [7:0] get_byte(state_t s, logic [POS_W-1:0] i);
    return s[{i, 3'b000} +: 8];
  endfunction

  function automatic state_t xor_byte(state_t s, logic [POS_W-1:0] i, logic [7:0] v);
    state_t r;
    r = s;
    r[{i, 3'b000} +: 8] = s[{i, 3'b000} +: 8] ^ v;
    return r;
  endfunction

  // One half mix over all four columns or diagonals; 16 steps per permutation.
  function automatic state_t perm_step(state_t s, logic [3:0] step);
    logic [31:0] w [16];
    logic [31:0] a, b, c, d;
    state_t r;
    int ib, ic, id;
    for (int k = 0; k < 16; k++) w[k] = s[32*k +: 32];
    if (!step[0]) w[0] = w[0] ^ RC[{step[3:2], step[1]}];
    for (int i = 0; i < 4; i++) begin
      ib = step[1] ? 4 + ((i + 1) & 3) : 4 + i;
      ic = step[1] ? 8 + ((i + 2) & 3) : 8 + i;
      id = step[1] ? 12 + ((i + 3) & 3) : 12 + i;
      a = w[i];
      b = w[ib];
      c = w[ic];
      d = w[id];
      c = c ^ a;
      d = d ^ b;
      a = a ^ (step[0] ? rotr(b & c, 30) : rotr(b & c, 24));
      b = b ^ (step[0] ? rotr(a & d, 16) : rotr(a & d, 9));
      w[i] = a;
      w[ib] = b;
      w[ic] = c;
      w[id] = d;
    end
    for (int k = 0; k < 16; k++) r[32*k +: 32] = w[k];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/spw_fifo.sv -----
// Short command queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module spw_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clear_i,
  input  wire logic          push_i,
  input  spw_pkg::cmd_t      data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output spw_pkg::cmd_t      data_o,
  output logic               valid_o
);

  spw_pkg::cmd_t                    mem_q [spw_pkg::FIFO_DEPTH];
  logic [spw_pkg::FIFO_PTR_W-1:0]   wr_q, rd_q;
  logic [spw_pkg::FIFO_PTR_W:0]     cnt_q;

  assign full_o  = (cnt_q == (spw_pkg::FIFO_PTR_W+1)'(spw_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (clear_i) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spw_front.sv -----
// Input side: accept items, track message phase, drop misfits, queue commands.
`timescale 1ns / 1ps
`default_nettype none
module spw_front #(
  parameter int RATE_BYTES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  spw_pkg::cfg_t    cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        seg_last_i,
  input  wire logic        seg_empty_i,
  input  wire logic        full_i,
  output logic             push_o,
  output spw_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] PH_KEY  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_TAG  = 2'd3;
  localparam logic [spw_pkg::POS_W-1:0] RATE_N = spw_pkg::POS_W'(RATE_BYTES);

  logic [1:0]                phase_q, phase_d;
  logic [spw_pkg::POS_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic                      match, ends, has, acc;
  spw_pkg::op_e              op;

  assign in_stall_o = full_i;
  assign acc  = in_valid_i && !full_i;
  assign ends = seg_empty_i || seg_last_i;
  assign has  = !seg_empty_i;
  assign cnt_inc = (has && cnt_q < RATE_N) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    match   = 1'b0;
    op      = spw_pkg::OP_MSG;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    unique case (cfg_i.mode) inside
      spw_pkg::MODE_HASH: begin
        match = (func_i == spw_pkg::FUNC_BODY);
      end
      spw_pkg::MODE_WRAP, spw_pkg::MODE_UNWRAP: begin
        unique case (phase_q)
          PH_KEY: begin
            match = (func_i == spw_pkg::FUNC_KEY);
            op    = spw_pkg::OP_KEY;
            if (ends) phase_d = PH_HDR;
          end
          PH_HDR: begin
            match = (func_i == spw_pkg::FUNC_HDR);
            op    = spw_pkg::OP_HDR;
            cnt_d = cnt_inc;
            if (ends) begin
              phase_d = (cnt_inc >= RATE_N) ? PH_KEY : PH_BODY;
              cnt_d   = '0;
            end
          end
          PH_BODY: begin
            match = (func_i == spw_pkg::FUNC_BODY);
            op    = spw_pkg::OP_BODY;
            if (ends) phase_d = (cfg_i.mode == spw_pkg::MODE_WRAP) ? PH_KEY : PH_TAG;
          end
          PH_TAG: begin
            match = (func_i == spw_pkg::FUNC_TAG);
            op    = spw_pkg::OP_TAG;
            if (ends) phase_d = PH_KEY;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign push_o     = acc && match && !cfg_i.clear;
  assign cmd_o.op   = op;
  assign cmd_o.has  = has;
  assign cmd_o.ends = ends;
  assign cmd_o.data = data_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KEY;
      cnt_q   <= '0;
    end else if (cfg_i.clear) begin
      phase_q <= PH_KEY;
      cnt_q   <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spw_back.sv -----
// Back side: sponge state, permutation sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spw_back #(
  parameter int RATE_BYTES   = 32,
  parameter int KEY_BYTES    = 16,
  parameter int DIGEST_BYTES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  spw_pkg::cfg_t    cfg_i,
  input  wire logic        cmd_valid_i,
  input  spw_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       out_kind_o,
  output logic             verdict_ok_o,
  output logic             run_last_o
);

  localparam int PW = spw_pkg::POS_W;
  localparam logic [PW-1:0] RATE_N   = PW'(RATE_BYTES);
  localparam logic [PW-1:0] LAST_POS = PW'(RATE_BYTES - 1);
  localparam logic [PW-1:0] KEY_N    = PW'(KEY_BYTES);
  localparam logic [PW-1:0] DIG_N    = PW'(DIGEST_BYTES);
  localparam logic [PW-1:0] DIG_LAST = PW'(DIGEST_BYTES - 1);
  localparam logic [PW-1:0] TIDX_MAX = PW'((KEY_BYTES > DIGEST_BYTES + 1) ?
                                           KEY_BYTES : DIGEST_BYTES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BYTE = 3'd1;
  localparam logic [2:0] ST_TEXT = 3'd2;
  localparam logic [2:0] ST_END  = 3'd3;
  localparam logic [2:0] ST_SKIP = 3'd4;
  localparam logic [2:0] ST_SQZ  = 3'd5;
  localparam logic [2:0] ST_PERM = 3'd6;

  spw_pkg::state_t   st_q, st_d;
  logic [PW-1:0]     pos_q, pos_d, tidx_q, tidx_d;
  logic              mism_q, mism_d;
  logic [2:0]        fsm_q, fsm_d, ret_q, ret_d, after;
  logic [3:0]        step_q, step_d;
  spw_pkg::cmd_t     cmd_q, cmd_d;
  logic              emit, emit_ok, clr;
  logic [7:0]        e_byte, t_byte;
  logic [1:0]        e_kind;
  logic              e_ok, e_last;
  logic              out_vld_q;

  assign emit_ok     = !out_vld_q || !out_stall_i;
  assign after       = cmd_q.ends ? ST_END : ST_IDLE;
  assign t_byte      = cmd_q.data ^ spw_pkg::get_byte(st_q, pos_q);
  assign out_valid_o = out_vld_q;

  always_comb begin
    st_d      = st_q;
    pos_d     = pos_q;
    tidx_d    = tidx_q;
    mism_d    = mism_q;
    fsm_d     = fsm_q;
    ret_d     = ret_q;
    step_d    = step_q;
    cmd_d     = cmd_q;
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    e_byte    = '0;
    e_kind    = spw_pkg::KIND_TEXT;
    e_ok      = 1'b0;
    e_last    = 1'b0;
    clr       = 1'b0;
    unique case (fsm_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          fsm_d     = cmd_i.has ? ST_BYTE : ST_END;
        end
      end
      ST_BYTE: begin
        fsm_d = after;
        case (cmd_q.op) inside
          spw_pkg::OP_MSG, spw_pkg::OP_KEY: begin
            if (cmd_q.op == spw_pkg::OP_MSG || tidx_q < KEY_N) begin
              st_d = spw_pkg::xor_byte(st_q, pos_q, cmd_q.data);
              if (cmd_q.op == spw_pkg::OP_KEY) tidx_d = tidx_q + 1'b1;
              if (pos_q == LAST_POS) begin
                pos_d = '0;
                ret_d = after;
                fsm_d = ST_PERM;
              end else begin
                pos_d = pos_q + 1'b1;
              end
            end
          end
          spw_pkg::OP_HDR: begin
            if (pos_q < RATE_N) begin
              st_d  = spw_pkg::xor_byte(st_q, pos_q, cmd_q.data);
              pos_d = pos_q + 1'b1;
            end
          end
          spw_pkg::OP_BODY: begin
            fsm_d = ST_TEXT;
            if (pos_q >= LAST_POS) begin
              st_d  = spw_pkg::xor_byte(
                        spw_pkg::xor_byte(st_q, pos_q, cfg_i.pad_ks), LAST_POS, 8'h01);
              pos_d = '0;
              ret_d = ST_TEXT;
              fsm_d = ST_PERM;
            end
          end
          spw_pkg::OP_TAG: begin
            if (tidx_q < DIG_N && spw_pkg::get_byte(st_q, tidx_q) != cmd_q.data) begin
              mism_d = 1'b1;
            end
            if (tidx_q <= DIG_N) tidx_d = tidx_q + 1'b1;
          end
          default: fsm_d = ST_IDLE;
        endcase
      end
      ST_TEXT: begin
        if (emit_ok) begin
          st_d   = spw_pkg::xor_byte(st_q, pos_q,
                     (cfg_i.mode == spw_pkg::MODE_WRAP) ? cmd_q.data : t_byte);
          pos_d  = pos_q + 1'b1;
          emit   = 1'b1;
          e_byte = t_byte;
          e_last = !cmd_q.ends || (cfg_i.mode == spw_pkg::MODE_UNWRAP);
          fsm_d  = after;
        end
      end
      ST_END: begin
        case (cmd_q.op)
          spw_pkg::OP_MSG: begin
            st_d  = spw_pkg::xor_byte(
                      spw_pkg::xor_byte(st_q, pos_q, cfg_i.pad_msg), LAST_POS, 8'h01);
            pos_d = '0;
            ret_d = ST_SQZ;
            fsm_d = ST_PERM;
          end
          spw_pkg::OP_KEY: fsm_d = ST_SKIP;
          spw_pkg::OP_HDR: begin
            if (pos_q >= RATE_N) begin
              if (emit_ok) begin
                emit   = 1'b1;
                e_kind = spw_pkg::KIND_ERROR;
                e_last = 1'b1;
                clr    = 1'b1;
                fsm_d  = ST_IDLE;
              end
            end else begin
              st_d  = spw_pkg::xor_byte(
                        spw_pkg::xor_byte(st_q, pos_q, cfg_i.pad_ks), LAST_POS, 8'h01);
              pos_d = '0;
              ret_d = ST_IDLE;
              fsm_d = ST_PERM;
            end
          end
          spw_pkg::OP_BODY: begin
            st_d   = spw_pkg::xor_byte(
                       spw_pkg::xor_byte(st_q, pos_q, cfg_i.pad_tag), LAST_POS, 8'h01);
            pos_d  = '0;
            tidx_d = '0;
            mism_d = 1'b0;
            ret_d  = (cfg_i.mode == spw_pkg::MODE_WRAP) ? ST_SQZ : ST_IDLE;
            fsm_d  = ST_PERM;
          end
          spw_pkg::OP_TAG: begin
            if (emit_ok) begin
              emit   = 1'b1;
              e_kind = spw_pkg::KIND_VERDICT;
              e_ok   = !mism_q && (tidx_q == DIG_N);
              e_last = 1'b1;
              clr    = 1'b1;
              fsm_d  = ST_IDLE;
            end
          end
          default: fsm_d = ST_IDLE;
        endcase
      end
      ST_SKIP: begin
        if (tidx_q < KEY_N) begin
          tidx_d = tidx_q + 1'b1;
          if (pos_q == LAST_POS) begin
            pos_d = '0;
            ret_d = ST_SKIP;
            fsm_d = ST_PERM;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end else begin
          st_d   = spw_pkg::xor_byte(
                     spw_pkg::xor_byte(st_q, pos_q, cfg_i.pad_ks), LAST_POS, 8'h01);
          pos_d  = '0;
          tidx_d = '0;
          ret_d  = ST_IDLE;
          fsm_d  = ST_PERM;
        end
      end
      ST_SQZ: begin
        if (pos_q == RATE_N) begin
          pos_d = '0;
          ret_d = ST_SQZ;
          fsm_d = ST_PERM;
        end else if (emit_ok) begin
          emit   = 1'b1;
          e_byte = spw_pkg::get_byte(st_q, pos_q);
          e_kind = spw_pkg::KIND_DIGEST;
          pos_d  = pos_q + 1'b1;
          tidx_d = tidx_q + 1'b1;
          if (tidx_q == DIG_LAST) begin
            e_last = 1'b1;
            clr    = 1'b1;
            fsm_d  = ST_IDLE;
          end
        end
      end
      ST_PERM: begin
        st_d   = spw_pkg::perm_step(st_q, step_q);
        step_d = step_q + 1'b1;
        if (step_q == 4'hF) fsm_d = ret_q;
      end
      default: fsm_d = ST_IDLE;
    endcase
    if (clr || cfg_i.clear) begin
      st_d   = '0;
      pos_d  = '0;
      tidx_d = '0;
      mism_d = 1'b0;
    end
    if (cfg_i.clear) begin
      fsm_d  = ST_IDLE;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      pos_q     <= '0;
      tidx_q    <= '0;
      mism_q    <= 1'b0;
      fsm_q     <= ST_IDLE;
      ret_q     <= ST_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      pos_q  <= pos_d;
      tidx_q <= tidx_d;
      mism_q <= mism_d;
      fsm_q  <= fsm_d;
      ret_q  <= ret_d;
      step_q <= step_d;
      if (emit) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_d;
    if (emit) begin
      out_byte_o   <= e_byte;
      out_kind_o   <= e_kind;
      verdict_ok_o <= e_ok;
      run_last_o   <= e_last;
    end
  end

  `SPW_CHECK(a_pos_range, pos_q <= RATE_N, "block position past rate")
  `SPW_CHECK(a_tidx_range, tidx_q <= TIDX_MAX, "byte counter out of range")
  `SPW_IMPLY(a_step_perm, fsm_q != ST_PERM, step_q == '0, "permutation step left mid-run")
  `SPW_IMPLY(a_emit_room, emit, !out_vld_q || !out_stall_i, "result overwrites held item")

endmodule
`default_nettype wire

// ----- rtl/sponge_hash_and_authenticated_wrap.sv -----
// Top level of the sponge hash and authenticated wrap block.
// Use: write mode and pad registers on the cfg channel (valid/ready, always
// ready) while the block is idle; a mode write drops any message in flight.
// Input items (func, data byte, segment flags) enter on the in channel
// (valid/stall); results leave on the out channel (valid/stall), one byte,
// kind, verdict and run_last per item.
// With the back side idle, a body byte's text item passes the command queue,
// the pop, execute and text steps of the back sequencer and the output register.
// Each key, header, message or tag byte takes the pop and execute steps of
// the back sequencer, each body byte the pop, execute and text steps, and a
// byte is done before the next pop. A permutation does one half mix of four
// columns or diagonals per cycle. Unless stalled, a digest or tag streams at
// one byte per cycle. A four-entry command queue lets input run ahead of
// a busy back side. Reset clears state, registers to their defaults and
// the queue. A stalled receiver holds the output register; the back side
// then waits, the queue fills and in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none
module sponge_hash_and_authenticated_wrap #(
  parameter int RATE_BYTES   = 32,
  parameter int KEY_BYTES    = 16,
  parameter int DIGEST_BYTES = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] func_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       seg_last_i,
  input  wire logic       seg_empty_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      out_kind_o,
  output logic            verdict_ok_o,
  output logic            run_last_o
);

  logic [1:0]    mode_q;
  logic [7:0]    pad_msg_q, pad_ks_q, pad_tag_q;
  spw_pkg::cfg_t cfg;
  logic          push, full, pop, cmd_vld;
  spw_pkg::cmd_t cmd_in, cmd_out;

  assign cfg_ready_o  = 1'b1;
  assign cfg.mode     = mode_q;
  assign cfg.pad_msg  = pad_msg_q;
  assign cfg.pad_ks   = pad_ks_q;
  assign cfg.pad_tag  = pad_tag_q;
  assign cfg.clear    = cfg_valid_i && (cfg_index_i == spw_pkg::CFG_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= spw_pkg::MODE_HASH;
      pad_msg_q <= 8'd1;
      pad_ks_q  <= 8'd2;
      pad_tag_q <= 8'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spw_pkg::CFG_MODE:    mode_q    <= cfg_data_i[1:0];
        spw_pkg::CFG_PAD_MSG: pad_msg_q <= cfg_data_i;
        spw_pkg::CFG_PAD_KS:  pad_ks_q  <= cfg_data_i;
        spw_pkg::CFG_PAD_TAG: pad_tag_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spw_front #(
    .RATE_BYTES (RATE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .seg_last_i  (seg_last_i),
    .seg_empty_i (seg_empty_i),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  spw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg.clear),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .valid_o (cmd_vld)
  );

  spw_back #(
    .RATE_BYTES   (RATE_BYTES),
    .KEY_BYTES    (KEY_BYTES),
    .DIGEST_BYTES (DIGEST_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_valid_i  (cmd_vld),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_kind_o   (out_kind_o),
    .verdict_ok_o (verdict_ok_o),
    .run_last_o   (run_last_o)
  );

endmodule
`default_nettype wire
